// File: rtl/iad_pkg.sv
package iad_pkg;

  localparam int unsigned W  = 64;
  localparam int unsigned HL = W / 2;
  localparam int unsigned HU = W - HL;

  typedef enum logic [7:0] {
    OP_ADD = 8'h01,
    OP_SUB = 8'h02,
    OP_MUL = 8'h03,
    OP_DIV = 8'h04,
    OP_MOD = 8'h05,
    OP_SHL = 8'h10,
    OP_OR  = 8'h11,
    OP_AND = 8'h12,
    OP_XOR = 8'h13,
    OP_CMP = 8'h14
  } op_e;

  typedef struct packed {
    logic [7:0]    cmd;
    logic [W-1:0]  rem;
    logic [W-1:0]  quo;
    logic [W-1:0]  dvs;
    logic          neg_q;
    logic          neg_r;
    logic          dz;
    logic [W-1:0]  res;
    logic [W-1:0]  p0;
    logic [HU-1:0] p12;
  } cell_t;

endpackage

// File: rtl/iad_front.sv
module iad_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [7:0]            cmd_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  output logic                  vld_o,
  output iad_pkg::cell_t        q_o
);
  import iad_pkg::*;

  logic [W-1:0]  a, b, res;
  logic [HL-1:0] al, bl;
  logic [HU-1:0] ah, bh;
  logic [5:0]    sh;
  cell_t         d;
  logic          vld_q;
  cell_t         q_q;

  assign a  = a_i[W-1:0];
  assign b  = b_i[W-1:0];
  assign al = a[HL-1:0];
  assign bl = b[HL-1:0];
  assign ah = a[W-1:HL];
  assign bh = b[W-1:HL];
  assign sh = b[5:0];

  always_comb begin
    unique case (cmd_i)
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_SHL: res = (7'(sh) >= 7'(W)) ? '0 : (a << sh);
      OP_OR:  res = a | b;
      OP_AND: res = a & b;
      OP_XOR: res = a ^ b;
      OP_CMP: begin
        if (a == b) res = '0;
        else if ($signed(a) > $signed(b)) res = '1;
        else res = W'(1);
      end
      default: res = '0;
    endcase
  end

  always_comb begin
    d.cmd   = cmd_i;
    d.rem   = '0;
    d.quo   = a[W-1] ? (W'(0) - a) : a;
    d.dvs   = b[W-1] ? (W'(0) - b) : b;
    d.neg_q = a[W-1] ^ b[W-1];
    d.neg_r = a[W-1];
    d.dz    = (b == '0);
    d.res   = res;
    d.p0    = W'(al) * W'(bl);
    d.p12   = HU'(ah * HU'(bl)) + HU'(HU'(al) * bh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = q_q;

endmodule

// File: rtl/iad_cell.sv
module iad_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  iad_pkg::cell_t d_i,
  output logic           vld_o,
  output iad_pkg::cell_t q_o
);
  import iad_pkg::*;

  logic [W:0]   trial;
  logic [W-1:0] shifted;
  logic         ge;
  cell_t        d;
  logic         vld_q;
  cell_t        q_q;

  // one restoring divide step per cell
  assign shifted = {d_i.rem[W-2:0], d_i.quo[W-1]};
  assign trial   = {d_i.rem, d_i.quo[W-1]} - {1'b0, d_i.dvs};
  assign ge      = !trial[W];

  always_comb begin
    d     = d_i;
    d.rem = ge ? trial[W-1:0] : shifted;
    d.quo = {d_i.quo[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = q_q;

endmodule

// File: rtl/integer_alu_with_divide.sv
// Pipelined 64-bit ALU, one beat accepted per cycle while the output is not stalled.
// The pipeline has an operand stage, 64 divide cells and an output register.
// A stall at the output freezes the whole chain; the input stalls with it.
// Reset (asynchronous, active low) clears all valid bits; data registers are not reset.
module integer_alu_with_divide (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  command_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] alu_result_o
);
  import iad_pkg::*;

  logic                en;
  logic                vld [0:W];
  cell_t               c   [0:W];
  cell_t               t;
  logic signed [W-1:0] r;
  logic                out_valid_q;
  logic [63:0]         alu_result_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  iad_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .cmd_i  (command_i),
    .a_i    (operand_a_i),
    .b_i    (operand_b_i),
    .vld_o  (vld[0]),
    .q_o    (c[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_cell
    iad_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[k]),
      .d_i    (c[k]),
      .vld_o  (vld[k+1]),
      .q_o    (c[k+1])
    );
  end

  assign t = c[W];

  always_comb begin
    unique case (t.cmd)
      OP_MUL:  r = t.p0 + {t.p12, {HL{1'b0}}};
      OP_DIV:  r = t.dz ? '0 : (t.neg_q ? (W'(0) - t.quo) : t.quo);
      OP_MOD:  r = t.dz ? '0 : (t.neg_r ? (W'(0) - t.rem) : t.rem);
      default: r = t.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      alu_result_q <= 64'(r);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign alu_result_o = alu_result_q;

`ifndef SYNTHESIS
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(alu_result_o))
    else $error("stalled beat changed");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld[W]))
    else $error("chain moved while stalled");
`endif

endmodule

// File: tb/tb_integer_alu_with_divide.sv
`timescale 1ns / 1ps

module tb_integer_alu_with_divide;
  import iad_pkg::*;

  localparam int LATENCY   = 66;
  localparam int IDLE_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  command_i;
  logic [63:0] operand_a_i;
  logic [63:0] operand_b_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] alu_result_o;

  logic [63:0] expected_results[$];
  int          mismatch_count;
  int          idle_cycles;
  bit          hold_off_req;
  bit          stall_enable;

  integer_alu_with_divide u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .alu_result_o(alu_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] alu_predict(logic [7:0] cmd, logic [63:0] a, logic [63:0] b);
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic [63:0]        mag_a;
    logic [63:0]        mag_b;
    logic [63:0]        q;
    logic [63:0]        r;
    sa = a;
    sb = b;
    mag_a = a[63] ? -a : a;
    mag_b = b[63] ? -b : b;
    r = '0;
    case (cmd)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV: begin
        if (b != 0) begin
          q = mag_a / mag_b;
          r = (a[63] != b[63]) ? -q : q;
        end
      end
      OP_MOD: begin
        if (b != 0) begin
          q = mag_a % mag_b;
          r = a[63] ? -q : q;
        end
      end
      OP_SHL: r = a << b[5:0];
      OP_OR:  r = a | b;
      OP_AND: r = a & b;
      OP_XOR: r = a ^ b;
      OP_CMP: r = (sa == sb) ? 64'd0 : (sa > sb) ? '1 : 64'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7fff_ffff_ffff_ffff;
      2: v = '1;
      3: v = '0;
      4: v = 64'(int'($urandom_range(0, 40)) - 20);
      5: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] rand_cmd();
    op_e ops[10] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
                     OP_SHL, OP_OR, OP_AND, OP_XOR, OP_CMP};
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return ops[$urandom_range(0, 9)];
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("ERROR %s: got %h expected %h", what, got, exp);
    mismatch_count++;
  endtask

  task automatic send_beat(logic [7:0] cmd, logic [63:0] a, logic [63:0] b, int gap);
    command_i   <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(alu_predict(cmd, a, b));
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic [63:0] mn;
    logic [63:0] mx;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7fff_ffff_ffff_ffff;
    send_beat(OP_ADD, mx, 64'd1, 0);
    send_beat(OP_SUB, mn, 64'd1, 0);
    send_beat(OP_MUL, mx, mx, 0);
    send_beat(OP_DIV, 64'd7, -64'd2, 0);
    send_beat(OP_DIV, mn, '1, 0);
    send_beat(OP_DIV, 64'd5, 64'd0, 1);
    send_beat(OP_MOD, -64'd7, 64'd2, 0);
    send_beat(OP_MOD, mn, '1, 0);
    send_beat(OP_MOD, mx, 64'd0, 2);
    send_beat(OP_SHL, '1, 64'd63, 0);
    send_beat(OP_SHL, 64'd1, 64'd64, 0);
    send_beat(OP_SHL, 64'h1234, '1, 0);
    send_beat(OP_OR, mn, mx, 0);
    send_beat(OP_AND, '1, mx, 0);
    send_beat(OP_XOR, '1, mn, 0);
    send_beat(OP_CMP, 64'd3, 64'd3, 0);
    send_beat(OP_CMP, mx, mn, 0);
    send_beat(OP_CMP, mn, mx, 0);
    send_beat(8'h00, mx, mx, 0);
    send_beat(8'hff, '1, '1, 0);
    send_beat(8'h06, 64'd1, 64'd1, 0);
    send_beat(OP_DIV, mn, 64'd1, 0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    repeat (n) send_beat(rand_cmd(), rand_word(), rand_word(), rand_gap());
  endtask

  task automatic test_back_pressure();
    hold_off_req = 1'b1;
    repeat (150) send_beat(rand_cmd(), rand_word(), rand_word(), 0);
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    int hold;
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_stall_i <= 1'b1;
      for (hold = 0; hold < 120; hold++) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end else if (stall_enable) begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (rand_gap() + 1) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected alu_result", alu_result_o, 'x);
      end else begin
        logic [63:0] exp;
        exp = expected_results.pop_front();
        if (alu_result_o !== exp) report_mismatch("alu_result", alu_result_o, exp);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    hold_off_req   = 1'b0;
    stall_enable   = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    command_i      = '0;
    operand_a_i    = '0;
    operand_b_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    stall_enable = 1'b1;
    test_random(200);
    wait_drained();
    stall_enable = 1'b0;
    test_random(80);
    test_back_pressure();
    stall_enable = 1'b1;
    test_random(150);
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
